// ----- rtl/subpel_mc_weighted_accumulate_macros.svh -----
// Assertion macros shared by the subpel motion-compensation RTL.
`ifndef SUBPEL_MC_WEIGHTED_ACCUMULATE_MACROS_SVH
`define SUBPEL_MC_WEIGHTED_ACCUMULATE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define SMWA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smwa assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SMWA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smwa assertion failed");

`else

`define SMWA_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define SMWA_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/smwa_pkg.sv -----
// Types and constants shared by the subpel motion-compensation pipeline.
`default_nettype none

package smwa_pkg;

   // Field widths.
   localparam int SAMPLE_W = 16;
   localparam int WEIGHT_W = 15;
   localparam int ACC_W    = 32;
   localparam int PIXEL_W  = 16;

   // Bilinear sum: four samples with weights summing to four, plus rounding.
   localparam int SUM_W        = SAMPLE_W + 3;
   localparam int BILIN_ROUND  = 2;
   localparam int BILIN_SHIFT  = 2;

   // Accumulator rounding down to pixel precision.
   localparam int ROUND_OFFSET = 1024;
   localparam int ROUND_SHIFT  = 11;
   localparam int ROUND_W      = ACC_W + 1 - ROUND_SHIFT;

   // Product of a signed sample and an unsigned weight.
   localparam int PROD_W = SAMPLE_W + WEIGHT_W + 1;

   // Operation codes.
   localparam logic FUNC_ACCUMULATE = 1'b0;
   localparam logic FUNC_ADD_PIXEL  = 1'b1;

   typedef struct packed {
      logic                       func;
      logic signed [SAMPLE_W-1:0] sample_tl;
      logic signed [SAMPLE_W-1:0] sample_tr;
      logic signed [SAMPLE_W-1:0] sample_bl;
      logic signed [SAMPLE_W-1:0] sample_br;
      logic                       frac_x;
      logic                       frac_y;
      logic        [WEIGHT_W-1:0] blend_weight;
      logic signed [ACC_W-1:0]    acc_in;
      logic signed [PIXEL_W-1:0]  pixel_in;
   } req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0]   acc_out;
      logic signed [PIXEL_W-1:0] pixel_out;
   } rsp_type;

   // After interpolation and rounding.
   typedef struct packed {
      logic                       func;
      logic signed [SAMPLE_W-1:0] interp;
      logic        [WEIGHT_W-1:0] weight;
      logic signed [ACC_W-1:0]    acc;
      logic signed [PIXEL_W-1:0]  rounded;
      logic signed [PIXEL_W-1:0]  pixel;
   } s1_type;

   // After the weight multiply and the pixel add.
   typedef struct packed {
      logic                      func;
      logic signed [PROD_W-1:0]  prod;
      logic signed [ACC_W-1:0]   acc;
      logic signed [PIXEL_W-1:0] pixel;
   } s2_type;

endpackage

`default_nettype wire

// ----- rtl/smwa_interp_stage.sv -----
// First pipeline stage: bilinear interpolation and accumulator rounding.
`default_nettype none

module smwa_interp_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire smwa_pkg::req_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output smwa_pkg::s1_type      out_data
);
   import smwa_pkg::*;

   logic                      valid_ff;
   s1_type                    data_ff;
   s1_type                    data_in;
   logic signed [SUM_W-1:0]   tl_x;
   logic signed [SUM_W-1:0]   tr_x;
   logic signed [SUM_W-1:0]   bl_x;
   logic signed [SUM_W-1:0]   br_x;
   logic signed [SUM_W-1:0]   wsum;
   logic signed [SUM_W-1:0]   rsum;
   logic signed [ACC_W:0]     acc_rnd;
   logic signed [ROUND_W-1:0] acc_shr;

   assign in_ready = !valid_ff || out_ready;

   // Weighted sample sum; weights are powers of two, so shifts suffice.
   always_comb begin
      tl_x = {{(SUM_W-SAMPLE_W){in_data.sample_tl[SAMPLE_W-1]}}, in_data.sample_tl};
      tr_x = {{(SUM_W-SAMPLE_W){in_data.sample_tr[SAMPLE_W-1]}}, in_data.sample_tr};
      bl_x = {{(SUM_W-SAMPLE_W){in_data.sample_bl[SAMPLE_W-1]}}, in_data.sample_bl};
      br_x = {{(SUM_W-SAMPLE_W){in_data.sample_br[SAMPLE_W-1]}}, in_data.sample_br};
      case ({in_data.frac_x, in_data.frac_y})
         2'b00:   wsum = tl_x <<< 2;
         2'b10:   wsum = (tl_x <<< 1) + (tr_x <<< 1);
         2'b01:   wsum = (tl_x <<< 1) + (bl_x <<< 1);
         default: wsum = tl_x + tr_x + bl_x + br_x;
      endcase
      rsum = wsum + SUM_W'(BILIN_ROUND);
   end

   // Accumulator rounding with a widened add, then saturation to pixel range.
   always_comb begin
      acc_rnd = {in_data.acc_in[ACC_W-1], in_data.acc_in} + (ACC_W+1)'(ROUND_OFFSET);
      acc_shr = acc_rnd[ACC_W:ROUND_SHIFT];
      data_in.func   = in_data.func;
      data_in.interp = rsum[BILIN_SHIFT +: SAMPLE_W];
      data_in.weight = in_data.blend_weight;
      data_in.acc    = in_data.acc_in;
      data_in.pixel  = in_data.pixel_in;
      if (acc_shr[ROUND_W-1:PIXEL_W-1] == '0 ||
          acc_shr[ROUND_W-1:PIXEL_W-1] == '1) begin
         data_in.rounded = acc_shr[PIXEL_W-1:0];
      end else if (acc_shr[ROUND_W-1]) begin
         data_in.rounded = {1'b1, {(PIXEL_W-1){1'b0}}};
      end else begin
         data_in.rounded = {1'b0, {(PIXEL_W-1){1'b1}}};
      end
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ----- rtl/smwa_weight_stage.sv -----
// Second pipeline stage: blend-weight multiply and pixel update.
`default_nettype none

module smwa_weight_stage (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire smwa_pkg::s1_type in_data,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output smwa_pkg::s2_type     out_data
);
   import smwa_pkg::*;

   logic   valid_ff;
   s2_type data_ff;
   s2_type data_in;

   assign in_ready = !valid_ff || out_ready;

   // Signed interpolated sample times the unsigned weight, and the pixel add.
   always_comb begin
      data_in.func = in_data.func;
      data_in.acc  = in_data.acc;
      data_in.prod = PROD_W'(in_data.interp) * PROD_W'(signed'({1'b0, in_data.weight}));
      if (in_data.func == FUNC_ADD_PIXEL) begin
         data_in.pixel = in_data.pixel + in_data.rounded;
      end else begin
         data_in.pixel = in_data.pixel;
      end
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ----- rtl/smwa_accum_stage.sv -----
// Third pipeline stage: accumulator update into the output register.
`default_nettype none

module smwa_accum_stage (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire smwa_pkg::s2_type in_data,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output smwa_pkg::rsp_type    out_data
);
   import smwa_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;
   rsp_type data_in;

   assign in_ready = !valid_ff || out_ready;

   // Wrapping accumulate in mode 0; mode 1 passes the accumulator through.
   always_comb begin
      data_in.pixel_out = in_data.pixel;
      if (in_data.func == FUNC_ACCUMULATE) begin
         data_in.acc_out = in_data.acc + {{(ACC_W-PROD_W){in_data.prod[PROD_W-1]}},
                                          in_data.prod};
      end else begin
         data_in.acc_out = in_data.acc;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ----- rtl/subpel_mc_weighted_accumulate.sv -----
// Top level of the subpel motion-compensation weighted-accumulate pipeline.
//
// One transaction on the req_ channel carries one pixel and an operation:
// func 0 interpolates four reference samples bilinearly by the fraction bits,
// scales the value by the blend weight and adds it to the accumulator; func 1
// rounds the accumulator down by eleven bits, saturates it and adds it to the
// pixel. Every request yields exactly one transaction on the rsp_ channel.
// The datapath is three register stages: interpolation and rounding, the
// 16 by 15 bit weight multiply, and the 32-bit accumulate into the output
// register; a result passes through each in turn. The pipeline takes one
// request per cycle for as long as rsp_ready stays high. When the receiver
// stalls, each stage holds its item and the stages before it keep taking
// new ones until they are full, so up to three results queue before
// req_ready drops. Synchronous reset empties all stages; data is kept.
`default_nettype none
`include "subpel_mc_weighted_accumulate_macros.svh"

module subpel_mc_weighted_accumulate (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire smwa_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output smwa_pkg::rsp_type      rsp_payload
);
   import smwa_pkg::*;

   logic   s1_valid;
   logic   s1_ready;
   s1_type s1_data;
   logic   s2_valid;
   logic   s2_ready;
   s2_type s2_data;

   // Interpolation and rounding.
   smwa_interp_stage u_interp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_payload),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   // Weight multiply and pixel add.
   smwa_weight_stage u_weight (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   // Accumulate into the output register.
   smwa_accum_stage u_accum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_payload)
   );

   // The pipeline takes a request whenever some stage is free.
   `SMWA_ASSERT_NOW(a_ready_when_room, clock, reset, !(s1_valid && s2_valid && rsp_valid), req_ready)

   // A round-and-add transaction leaves the accumulator untouched.
   `SMWA_ASSERT_NEXT(a_acc_passthru, clock, reset, s2_valid && s2_ready && (s2_data.func == FUNC_ADD_PIXEL), rsp_payload.acc_out == $past(s2_data.acc))

   // A delivered result with nothing behind it leaves the output empty.
   `SMWA_ASSERT_NEXT(a_drain_empty, clock, reset, rsp_valid && rsp_ready && !s2_valid, !rsp_valid)

endmodule

`default_nettype wire
